### rtl/srd_pkg.sv
// Package for the spiral-order matrix reader: sizes, payload structs,
// side-of-ring enum and dimension clamp helper. No dependencies.
package srd_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int POS_W      = 4;
    localparam int DIM_W      = 5;
    localparam int ADDR_W     = 2 * POS_W;
    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int CFG_IDX_W  = 1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd4;

    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_BOTTOM = 2'd2,
        SIDE_LEFT   = 2'd3
    } t_side;

    typedef struct packed {
        logic                         kind;
        logic [POS_W-1:0]             row;
        logic [POS_W-1:0]             col;
        logic signed [DATA_WIDTH-1:0] value;
    } t_srd_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] elem_value;
        logic [POS_W-1:0]             elem_row;
        logic [POS_W-1:0]             elem_col;
        logic                         last;
    } t_srd_out;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_srd_pos;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end
        return res;
    endfunction

endpackage

### rtl/srd_store.sv
// Element memory: one write port and one registered read port.
// Depends on srd_pkg for sizes.
module srd_store
    import srd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic signed [DATA_WIDTH-1:0] i_wdata,
    input  logic                         i_re,
    input  logic [ADDR_W-1:0]            i_raddr,
    output logic signed [DATA_WIDTH-1:0] o_rdata
);

    logic signed [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold the read word while the result waits downstream
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/srd_walker.sv
// Spiral position sequencer: ring, side and current row/column, stepped
// once per read transaction. Depends on srd_pkg for t_side and t_srd_pos.
module srd_walker
    import srd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_restart,
    input  logic             i_step,
    input  logic [DIM_W-1:0] i_rows,
    input  logic [DIM_W-1:0] i_cols,
    output t_srd_pos         o_pos
);

    logic [POS_W-1:0] r_ring, n_ring;
    logic [POS_W-1:0] r_row, n_row;
    logic [POS_W-1:0] r_col, n_col;
    t_side            r_side, n_side;

    logic [DIM_W-1:0] top_w, bot_w, right_w, row_w, col_w, k_w;
    logic             ring_more;
    logic             go_next;
    logic             w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring <= '0;
            r_row  <= '0;
            r_col  <= '0;
            r_side <= SIDE_TOP;
        end else begin
            r_ring <= n_ring;
            r_row  <= n_row;
            r_col  <= n_col;
            r_side <= n_side;
        end
    end

    always_comb begin
        top_w     = {1'b0, r_ring};
        bot_w     = i_rows - DIM_W'(1) - top_w;
        right_w   = i_cols - DIM_W'(1) - top_w;
        row_w     = {1'b0, r_row};
        col_w     = {1'b0, r_col};
        k_w       = top_w + DIM_W'(1);
        ring_more = ({k_w, 1'b0} < {1'b0, i_rows}) && ({k_w, 1'b0} < {1'b0, i_cols});
    end

    // next state
    always_comb begin
        n_ring  = r_ring;
        n_row   = r_row;
        n_col   = r_col;
        n_side  = r_side;
        go_next = 1'b0;
        w_done  = 1'b0;
        if (i_restart) begin
            n_ring = '0;
            n_row  = '0;
            n_col  = '0;
            n_side = SIDE_TOP;
        end else if (i_step) begin
            unique case (r_side)
                SIDE_TOP: begin
                    if (col_w < right_w) begin
                        n_col = r_col + POS_W'(1);
                    end else if (bot_w > top_w) begin
                        n_side = SIDE_RIGHT;
                        n_row  = POS_W'(top_w + DIM_W'(1));
                        n_col  = right_w[POS_W-1:0];
                    end else begin
                        go_next = 1'b1;
                    end
                end
                SIDE_RIGHT: begin
                    if (row_w < bot_w) begin
                        n_row = r_row + POS_W'(1);
                    end else if (right_w > top_w) begin
                        n_side = SIDE_BOTTOM;
                        n_row  = bot_w[POS_W-1:0];
                        n_col  = POS_W'(right_w - DIM_W'(1));
                    end else begin
                        go_next = 1'b1;
                    end
                end
                SIDE_BOTTOM: begin
                    if (col_w > top_w) begin
                        n_col = r_col - POS_W'(1);
                    end else if ((bot_w - top_w) >= DIM_W'(2)) begin
                        n_side = SIDE_LEFT;
                        n_row  = POS_W'(bot_w - DIM_W'(1));
                        n_col  = r_ring;
                    end else begin
                        go_next = 1'b1;
                    end
                end
                SIDE_LEFT: begin
                    if (row_w > top_w + DIM_W'(1)) begin
                        n_row = r_row - POS_W'(1);
                    end else begin
                        go_next = 1'b1;
                    end
                end
                default: begin
                    go_next = 1'b1;
                end
            endcase
            // step inward one ring, or wrap to the corner at the end of a pass
            if (go_next) begin
                n_side = SIDE_TOP;
                if (ring_more) begin
                    n_ring = k_w[POS_W-1:0];
                    n_row  = k_w[POS_W-1:0];
                    n_col  = k_w[POS_W-1:0];
                end else begin
                    n_ring = '0;
                    n_row  = '0;
                    n_col  = '0;
                    w_done = 1'b1;
                end
            end
        end
    end

    // outputs
    always_comb begin
        o_pos.row  = r_row;
        o_pos.col  = r_col;
        o_pos.last = w_done;
    end

endmodule

### rtl/spiral_order_matrix_reader_unit.sv
// Spiral-order matrix reader: accepts one transaction per cycle. A write
// transaction stores one element and rewinds the walk to the top-left corner;
// a read transaction returns the next element in clockwise spiral order in the
// cycle after acceptance, from the element memory's registered read port. A
// waiting result holds off the input until it is taken; a result taken in the
// same cycle lets the next transaction in.
// Writing num_rows or num_cols also rewinds the walk. No clearing pass.
// Depends on srd_pkg, srd_store and srd_walker.
module spiral_order_matrix_reader_unit
    import srd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_srd_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_srd_out             o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    logic [DIM_W-1:0]  r_num_rows;
    logic [DIM_W-1:0]  r_num_cols;
    logic              r_valid;
    logic [POS_W-1:0]  r_row;
    logic [POS_W-1:0]  r_col;
    logic              r_last;

    logic              in_acc;
    logic              wr_acc;
    logic              rd_acc;
    logic [DIM_W-1:0]  rows_c;
    logic [DIM_W-1:0]  cols_c;
    t_srd_pos          pos;
    logic signed [DATA_WIDTH-1:0] rdata;

    assign o_in_ready = !r_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_acc     = in_acc && (i_in_data.kind == KIND_WRITE);
    assign rd_acc     = in_acc && (i_in_data.kind == KIND_READ);
    assign rows_c     = clamp_dim(r_num_rows, DIM_W'(MAX_ROWS));
    assign cols_c     = clamp_dim(r_num_cols, DIM_W'(MAX_COLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= DIM_RESET;
            r_num_cols <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    srd_store u_store (
        .i_clk   (i_clk),
        .i_we    (wr_acc),
        .i_waddr ({i_in_data.row, i_in_data.col}),
        .i_wdata (i_in_data.value),
        .i_re    (rd_acc),
        .i_raddr ({pos.row, pos.col}),
        .o_rdata (rdata)
    );

    srd_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (wr_acc || i_cfg_we),
        .i_step    (rd_acc),
        .i_rows    (rows_c),
        .i_cols    (cols_c),
        .o_pos     (pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rd_acc) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_acc) begin
            r_row  <= pos.row;
            r_col  <= pos.col;
            r_last <= pos.last;
        end
    end

    assign o_out_valid           = r_valid;
    assign o_out_data.elem_value = rdata;
    assign o_out_data.elem_row   = r_row;
    assign o_out_data.elem_col   = r_col;
    assign o_out_data.last       = r_last;

endmodule

### rtl/srd_checker.sv
// Port-level checker for the spiral-order matrix reader, bound to the top level.
// Depends on srd_pkg.
module srd_checker
    import srd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input t_srd_in              i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_srd_out             o_out_data
);

    logic acc;
    assign acc = i_in_valid && o_in_ready;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in_data.kind == KIND_READ) |=> o_out_valid)
        else $error("read transaction gave no result");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in_data.kind == KIND_WRITE && !o_out_valid) |=> !o_out_valid)
        else $error("write transaction produced a result");

    // a write rewinds the walk to the corner
    a_write_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in_data.kind == KIND_WRITE) ##1 (acc && i_in_data.kind == KIND_READ)
        |=> (o_out_data.elem_row == '0 && o_out_data.elem_col == '0))
        else $error("read after write did not start at the corner");

endmodule

bind spiral_order_matrix_reader_unit srd_checker u_srd_checker (.*);
